FILE: rtl/core/sirf_pkg.sv
`timescale 1ns / 1ps

package sirf_pkg;

  localparam int IDX_W      = 12;
  localparam int BASE_W     = 8;
  localparam int LEN_W      = 13;
  localparam int PLEN_W     = 13;
  localparam int START_W    = 13;
  localparam int END_W      = 14;
  localparam int POS_W      = 14;
  localparam int ARM_W      = 13;
  localparam int MINL_W     = 13;
  localparam int SPC_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int SEQ_DEPTH_DEF = 4096;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACER     = 1'd1;

  localparam logic [MINL_W-1:0] MIN_LENGTH_RST = 13'd8;
  localparam logic [SPC_W-1:0]  SPACER_RST     = 12'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_MATCH,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch a query and set up the arms
    logic wr;        // store a base
    logic rd_cur;    // read the pair at the current arm
    logic rd_next;   // read the pair one step further out
    logic step;      // the current pair matched; move both arms out
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic inb_cur;   // both current positions lie inside the sequence
    logic inb_next;  // both positions one step out lie inside the sequence
    logic pair;      // the bases read last cycle are complementary
    logic out_busy;  // output register holds a beat that is not taken
  } dp_stat_t;

  function automatic logic pairs_with(input logic [BASE_W-1:0] l, input logic [BASE_W-1:0] r);
    logic ok;
    ok = 1'b0;
    case (l)
      "A":     ok = (r == "T");
      "T":     ok = (r == "A");
      "G":     ok = (r == "C");
      "C":     ok = (r == "G");
      "a":     ok = (r == "t");
      "t":     ok = (r == "a");
      "g":     ok = (r == "c");
      "c":     ok = (r == "g");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/core/sirf_in_if.sv
`timescale 1ns / 1ps

interface sirf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [sirf_pkg::IDX_W-1:0]  index;
  logic [sirf_pkg::BASE_W-1:0] base;
  logic [sirf_pkg::LEN_W-1:0]  seq_len;

  modport source (output valid, cmd, index, base, seq_len, input ready);
  modport sink   (input valid, cmd, index, base, seq_len, output ready);
endinterface

FILE: rtl/core/sirf_out_if.sv
`timescale 1ns / 1ps

interface sirf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [sirf_pkg::PLEN_W-1:0]  pal_length;
  logic [sirf_pkg::START_W-1:0] start_pos;
  logic [sirf_pkg::END_W-1:0]   end_pos;

  modport source (output valid, hit, pal_length, start_pos, end_pos, input ready);
  modport sink   (input valid, hit, pal_length, start_pos, end_pos, output ready);
endinterface

FILE: rtl/core/sirf_cfg_if.sv
`timescale 1ns / 1ps

interface sirf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sirf_pkg::CFG_IDX_W-1:0]  index;
  logic [sirf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sirf_ram.sv
`timescale 1ns / 1ps

module sirf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/sirf_ctrl.sv
`timescale 1ns / 1ps

module sirf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  input  sirf_pkg::dp_stat_t stat,
  output sirf_pkg::dp_cmd_t  cmd
);

  sirf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sirf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sirf_pkg::ST_IDLE: begin
        if (in_valid && in_cmd == sirf_pkg::CMD_QUERY) begin
          state_nxt = sirf_pkg::ST_PROBE;
        end
      end
      sirf_pkg::ST_PROBE: begin
        state_nxt = stat.inb_cur ? sirf_pkg::ST_MATCH : sirf_pkg::ST_DONE;
      end
      sirf_pkg::ST_MATCH: begin
        if (!(stat.pair && stat.inb_next)) begin
          state_nxt = sirf_pkg::ST_DONE;
        end
      end
      sirf_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = sirf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sirf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      sirf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == sirf_pkg::CMD_QUERY) begin
            cmd.load = 1'b1;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      sirf_pkg::ST_PROBE: begin
        cmd.rd_cur = stat.inb_cur;
      end
      sirf_pkg::ST_MATCH: begin
        // The next pair is fetched while this one is compared.
        if (stat.pair) begin
          cmd.step    = 1'b1;
          cmd.rd_next = stat.inb_next;
        end
      end
      sirf_pkg::ST_DONE: begin
        cmd.load_out = !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/sirf_dp.sv
`timescale 1ns / 1ps

module sirf_dp #(
  parameter int SEQ_DEPTH = sirf_pkg::SEQ_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sirf_pkg::IDX_W-1:0]       in_index,
  input  logic [sirf_pkg::BASE_W-1:0]      in_base,
  input  logic [sirf_pkg::LEN_W-1:0]       in_seq_len,
  input  logic                             cfg_valid,
  input  logic [sirf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sirf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [sirf_pkg::PLEN_W-1:0]      out_pal_length,
  output logic [sirf_pkg::START_W-1:0]     out_start_pos,
  output logic [sirf_pkg::END_W-1:0]       out_end_pos,
  input  sirf_pkg::dp_cmd_t                cmd,
  output sirf_pkg::dp_stat_t               stat
);

  localparam int AW      = $clog2(SEQ_DEPTH);
  localparam int LEN_MAX = (1 << sirf_pkg::LEN_W) - 1;
  localparam int LEN_LIM = (SEQ_DEPTH < LEN_MAX) ? SEQ_DEPTH : LEN_MAX;
  localparam int IDX_CNT = 1 << sirf_pkg::IDX_W;
  localparam int WR_LIM  = (SEQ_DEPTH < IDX_CNT) ? SEQ_DEPTH : IDX_CNT;

  localparam logic [sirf_pkg::POS_W-1:0] LEN_LIM_P = sirf_pkg::POS_W'(LEN_LIM);
  localparam logic [sirf_pkg::IDX_W:0]   WR_LIM_P  = (sirf_pkg::IDX_W + 1)'(WR_LIM);

  logic [sirf_pkg::MINL_W-1:0] min_length_r;
  logic [sirf_pkg::SPC_W-1:0]  spacer_r;

  logic [sirf_pkg::IDX_W-1:0] idx_r;
  logic [sirf_pkg::POS_W-1:0] len_r;
  logic [sirf_pkg::ARM_W-1:0] arm_r;
  logic [sirf_pkg::IDX_W-1:0] lpos_r;
  logic [sirf_pkg::POS_W-1:0] rpos_r;

  logic                         out_valid_r;
  logic                         hit_r;
  logic [sirf_pkg::PLEN_W-1:0]  plen_r;
  logic [sirf_pkg::START_W-1:0] start_r;
  logic [sirf_pkg::END_W-1:0]   end_r;

  logic [sirf_pkg::POS_W-1:0]  len_eff;
  logic [sirf_pkg::ARM_W-1:0]  arm_inc;
  logic [sirf_pkg::POS_W-1:0]  rpos_inc;
  logic [sirf_pkg::IDX_W-1:0]  lpos_dec;
  logic [sirf_pkg::IDX_W-1:0]  rd_lpos;
  logic [sirf_pkg::POS_W-1:0]  rd_rpos;
  logic                        wr_en;
  logic                        rd_en;
  logic [sirf_pkg::BASE_W-1:0] ldata;
  logic [sirf_pkg::BASE_W-1:0] rdata;
  logic [sirf_pkg::POS_W-1:0]  plen_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= sirf_pkg::MIN_LENGTH_RST;
      spacer_r     <= sirf_pkg::SPACER_RST;
    end else if (cfg_valid) begin
      if (cfg_index == sirf_pkg::REG_MIN_LENGTH) begin
        min_length_r <= cfg_data;
      end else if (cfg_index == sirf_pkg::REG_SPACER) begin
        spacer_r <= cfg_data[sirf_pkg::SPC_W-1:0];
      end
    end
  end

  assign len_eff = (sirf_pkg::POS_W'(in_seq_len) > LEN_LIM_P) ? LEN_LIM_P
                                                               : sirf_pkg::POS_W'(in_seq_len);

  assign arm_inc  = arm_r + 1'b1;
  assign rpos_inc = rpos_r + 1'b1;
  assign lpos_dec = lpos_r - 1'b1;

  // The left arm is still inside while arm <= center.
  assign stat.inb_cur  = (arm_r <= sirf_pkg::ARM_W'(idx_r)) && (rpos_r < len_r);
  assign stat.inb_next = (arm_inc <= sirf_pkg::ARM_W'(idx_r)) && (rpos_inc < len_r);
  assign stat.pair     = sirf_pkg::pairs_with(ldata, rdata);
  assign stat.out_busy = out_valid_r && !out_ready;

  // Arm registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= in_index;
      len_r  <= len_eff;
      arm_r  <= '0;
      lpos_r <= in_index;
      rpos_r <= sirf_pkg::POS_W'(in_index) + sirf_pkg::POS_W'(spacer_r) + 1'b1;
    end else if (cmd.step) begin
      arm_r  <= arm_inc;
      lpos_r <= lpos_dec;
      rpos_r <= rpos_inc;
    end
  end

  // Sequence store.
  assign wr_en   = cmd.wr && ({1'b0, in_index} < WR_LIM_P);
  assign rd_en   = cmd.rd_cur || cmd.rd_next;
  assign rd_lpos = cmd.rd_next ? lpos_dec : lpos_r;
  assign rd_rpos = cmd.rd_next ? rpos_inc : rpos_r;

  sirf_ram #(
    .WIDTH (sirf_pkg::BASE_W),
    .DEPTH (SEQ_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (AW'(in_index)),
    .wdata   (in_base),
    .re      (rd_en),
    .raddr_a (AW'(rd_lpos)),
    .raddr_b (AW'(rd_rpos)),
    .rdata_a (ldata),
    .rdata_b (rdata)
  );

  // Output register.
  assign plen_full = {arm_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit_r   <= plen_full >= sirf_pkg::POS_W'(min_length_r);
      plen_r  <= plen_full[sirf_pkg::PLEN_W-1:0];
      start_r <= sirf_pkg::START_W'(idx_r) - arm_r + sirf_pkg::START_W'(2);
      end_r   <= rpos_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = hit_r;
  assign out_pal_length = plen_r;
  assign out_start_pos  = start_r;
  assign out_end_pos    = end_r;

endmodule

FILE: rtl/core/spaced_inverted_repeat_finder.sv
`timescale 1ns / 1ps
// A base write is accepted while idle, and writes can follow back to back.
// A query walks its arms outward one matched pair per cycle and stops on a mismatch or at an
// end of the sequence; arm, the number of matched pairs, then sets the result.
// The next item is accepted in the cycle after the result enters the output register, so a query
// holds the input until then, and longer while a stalled result fills that register.
// Synchronous active-low reset sets min_length to 8 and spacer to 0; the store is not cleared.

module spaced_inverted_repeat_finder #(
  parameter int SEQ_DEPTH = sirf_pkg::SEQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sirf_in_if.sink           in_ch,
  sirf_out_if.source        out_ch,
  sirf_cfg_if.sink          cfg_ch
);

  sirf_pkg::dp_cmd_t  cmd;
  sirf_pkg::dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  sirf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sirf_dp #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_index       (in_ch.index),
    .in_base        (in_ch.base),
    .in_seq_len     (in_ch.seq_len),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_hit        (out_ch.hit),
    .out_pal_length (out_ch.pal_length),
    .out_start_pos  (out_ch.start_pos),
    .out_end_pos    (out_ch.end_pos),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

FILE: rtl/core/sirf_chk.sv
`timescale 1ns / 1ps

module sirf_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_cmd,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [sirf_pkg::PLEN_W-1:0]     out_pal_length,
  input logic [sirf_pkg::START_W-1:0]    out_start_pos,
  input logic [sirf_pkg::END_W-1:0]      out_end_pos
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_pal_length) && $stable(out_start_pos) && $stable(out_end_pos))
    else $error("result beat changed while stalled");

  // An accepted query moves the block out of idle, which drops input ready.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == sirf_pkg::CMD_QUERY |=> !in_ready)
    else $error("input accepted right after a query");

  // The length is twice the number of matched base pairs, so it is always even.
  a_even_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pal_length[0] == 1'b0)
    else $error("odd palindrome length");

  // Positions are 1-based and the start never wraps to zero.
  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_start_pos != '0)
    else $error("start position is zero");

endmodule

bind spaced_inverted_repeat_finder sirf_chk u_sirf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_cmd         (in_ch.cmd),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_pal_length (out_ch.pal_length),
  .out_start_pos  (out_ch.start_pos),
  .out_end_pos    (out_ch.end_pos)
);

FILE: dv/tb_spaced_inverted_repeat_finder.sv
`timescale 1ns / 1ps

import sirf_pkg::*;

typedef struct packed {
  logic              cmd;
  logic [IDX_W-1:0]  index;
  logic [BASE_W-1:0] base;
  logic [LEN_W-1:0]  seq_len;
} seq_beat_t;

typedef struct packed {
  logic               hit;
  logic [PLEN_W-1:0]  pal_length;
  logic [START_W-1:0] start_pos;
  logic [END_W-1:0]   end_pos;
} pal_result_t;

class pal_scoreboard;
  logic [BASE_W-1:0] store [SEQ_DEPTH_DEF];
  bit                written [SEQ_DEPTH_DEF];
  int unsigned       min_length;
  int unsigned       spacer;
  pal_result_t       pal_q [$];
  int                errors;
  int                queries;
  int                hits;
  int                longest;

  function new();
    min_length = MIN_LENGTH_RST;
    spacer     = SPACER_RST;
    errors     = 0;
    queries    = 0;
    hits       = 0;
    longest    = 0;
  endfunction

  // Base that pairs with b, or zero when b pairs with nothing.
  function logic [BASE_W-1:0] partner(logic [BASE_W-1:0] b);
    case (b)
      "A": return "T";
      "T": return "A";
      "G": return "C";
      "C": return "G";
      "a": return "t";
      "t": return "a";
      "g": return "c";
      "c": return "g";
      default: return '0;
    endcase
  endfunction

  function bit is_pair(logic [BASE_W-1:0] l, logic [BASE_W-1:0] r);
    logic [BASE_W-1:0] p;
    p = partner(l);
    return (p != '0) && (p == r);
  endfunction

  function int seq_limit(logic [LEN_W-1:0] len);
    return (len > SEQ_DEPTH_DEF) ? SEQ_DEPTH_DEF : int'(len);
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_MIN_LENGTH) begin
      min_length = data;
    end else begin
      spacer = data[SPC_W-1:0];
    end
  endfunction

  // First entry a query would read that was never written, or -1 if none.
  function int unwritten_read(logic [IDX_W-1:0] center, logic [LEN_W-1:0] len);
    int l, r, lim;
    l = center;
    r = int'(center) + 1 + int'(spacer);
    lim = seq_limit(len);
    while (l >= 0 && r < lim) begin
      if (!written[l]) return l;
      if (!written[r]) return r;
      if (!is_pair(store[l], store[r])) return -1;
      l--;
      r++;
    end
    return -1;
  endfunction

  function pal_result_t walk_arms(logic [IDX_W-1:0] center, logic [LEN_W-1:0] len);
    pal_result_t res;
    int l, r, lim, arm;
    l = center;
    r = int'(center) + 1 + int'(spacer);
    lim = seq_limit(len);
    while (l >= 0 && r < lim && is_pair(store[l], store[r])) begin
      l--;
      r++;
    end
    arm = int'(center) - l;
    res.hit        = (2 * arm >= int'(min_length));
    res.pal_length = PLEN_W'(2 * arm);
    res.start_pos  = START_W'(l + 2);
    res.end_pos    = END_W'(int'(center) + arm + int'(spacer) + 1);
    return res;
  endfunction

  function void note_input(seq_beat_t b);
    pal_result_t res;
    if (b.cmd == CMD_WRITE) begin
      store[b.index]   = b.base;
      written[b.index] = 1'b1;
    end else begin
      res = walk_arms(b.index, b.seq_len);
      pal_q.push_back(res);
      queries++;
      if (res.hit) hits++;
      if (res.pal_length > longest) longest = res.pal_length;
    end
  endfunction

  function void check_result(pal_result_t got);
    pal_result_t exp_res;
    if (pal_q.size() == 0) begin
      $error("result beat with no query outstanding: pal_length %0d", got.pal_length);
      errors++;
      return;
    end
    exp_res = pal_q.pop_front();
    if (got.hit !== exp_res.hit) begin
      $error("hit: expected %0d, actual %0d", exp_res.hit, got.hit);
      errors++;
    end
    if (got.pal_length !== exp_res.pal_length) begin
      $error("pal_length: expected %0d, actual %0d", exp_res.pal_length, got.pal_length);
      errors++;
    end
    if (got.start_pos !== exp_res.start_pos) begin
      $error("start_pos: expected %0d, actual %0d", exp_res.start_pos, got.start_pos);
      errors++;
    end
    if (got.end_pos !== exp_res.end_pos) begin
      $error("end_pos: expected %0d, actual %0d", exp_res.end_pos, got.end_pos);
      errors++;
    end
  endfunction

  function int outstanding();
    return pal_q.size();
  endfunction
endclass

module tb_spaced_inverted_repeat_finder;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int SEGMENT_BEATS   = 250;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sirf_in_if  in_ch ();
  sirf_out_if out_ch ();
  sirf_cfg_if cfg_ch ();

  spaced_inverted_repeat_finder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pal_scoreboard sb = new();

  int send_idle_pct  = 0;
  int take_stall_pct = 0;
  int beats_sent     = 0;
  int cfg_writes     = 0;

  always #5 clk = ~clk;

  function automatic logic [BASE_W-1:0] random_dna();
    case ($urandom_range(7))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      4: return "a";
      5: return "c";
      6: return "g";
      default: return "t";
    endcase
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    if ($urandom_range(99) < 85) return random_dna();
    return BASE_W'($urandom_range(255));
  endfunction

  task automatic send_beat(seq_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= b.cmd;
    in_ch.index   <= b.index;
    in_ch.base    <= b.base;
    in_ch.seq_len <= b.seq_len;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b);
    beats_sent++;
  endtask

  task automatic write_base(int idx, logic [BASE_W-1:0] b);
    seq_beat_t beat;
    beat.cmd     = CMD_WRITE;
    beat.index   = IDX_W'(idx);
    beat.base    = b;
    beat.seq_len = LEN_W'($urandom_range(8191));
    send_beat(beat);
  endtask

  // Any entry the walk would reach without a prior write gets one first.
  task automatic query(logic [IDX_W-1:0] center, logic [LEN_W-1:0] len);
    seq_beat_t beat;
    int p;
    p = sb.unwritten_read(center, len);
    while (p >= 0) begin
      write_base(p, random_base());
      p = sb.unwritten_read(center, len);
    end
    beat.cmd     = CMD_QUERY;
    beat.index   = center;
    beat.base    = BASE_W'($urandom_range(255));
    beat.seq_len = len;
    send_beat(beat);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(idx, data);
    cfg_writes++;
  endtask

  // The spare top bit of the spacer write is random; only 12 bits are kept.
  task automatic configure(int min_len, int spc);
    drain();
    cfg_write(REG_MIN_LENGTH, CFG_DATA_W'(min_len));
    cfg_write(REG_SPACER, {1'($urandom_range(1)), SPC_W'(spc)});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic build_palindrome();
    int arm, hi, lo, center, k, len;
    logic [BASE_W-1:0] b;
    arm = ($urandom_range(19) == 0) ? $urandom_range(64) : $urandom_range(10);
    hi = SEQ_DEPTH_DEF - 1 - int'(sb.spacer) - arm;
    lo = (arm == 0) ? 0 : arm - 1;
    if (hi < lo) begin
      query(IDX_W'($urandom_range(4095)), LEN_W'($urandom_range(8191)));
      return;
    end
    center = $urandom_range(hi, lo);
    for (k = 0; k < arm; k++) begin
      b = random_dna();
      write_base(center - k, b);
      write_base(center + 1 + int'(sb.spacer) + k, sb.partner(b));
    end
    // Usually close the arms with a pair that most likely breaks the match.
    if ($urandom_range(3) != 0 && center - arm >= 0 &&
        center + 1 + int'(sb.spacer) + arm < SEQ_DEPTH_DEF) begin
      write_base(center - arm, random_base());
      write_base(center + 1 + int'(sb.spacer) + arm, random_base());
    end
    case ($urandom_range(6))
      0: len = $urandom_range(8191);
      1: len = center + int'(sb.spacer) + 1 + $urandom_range(arm);
      default: len = center + int'(sb.spacer) + arm + 1 + $urandom_range(3);
    endcase
    query(IDX_W'(center), LEN_W'(len));
  endtask

  task automatic random_query();
    int center, len;
    center = $urandom_range(4095);
    case ($urandom_range(4))
      0: len = $urandom_range(8191);
      1: len = $urandom_range(64);
      default: len = center + int'(sb.spacer) + 1 + $urandom_range(40);
    endcase
    query(IDX_W'(center), LEN_W'(len));
  endtask

  task automatic random_segment(int min_len, int spc, int mode);
    int first, pick;
    configure(min_len, spc);
    case (mode)
      0: begin
        send_idle_pct  = 22;
        take_stall_pct = 51;
      end
      1: begin
        send_idle_pct  = 51;
        take_stall_pct = 22;
      end
      default: begin
        send_idle_pct  = 0;
        take_stall_pct = 0;
      end
    endcase
    first = beats_sent;
    while (beats_sent - first < SEGMENT_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        build_palindrome();
      end else if (pick < 75) begin
        random_query();
      end else begin
        write_base($urandom_range(4095), random_base());
      end
      // Now and then hold the sender until every pending result is back.
      if ($urandom_range(99) < 2) drain();
    end
  endtask

  task automatic directed_part();
    write_base(0, "A");
    write_base(1, "C");
    write_base(2, "G");
    write_base(3, "T");
    query(1, 4);
    query(1, 13'd8191);
    query(12'd4095, 13'd4096);
    query(0, 0);
    write_base(4095, 8'hFF);
    write_base(4094, 8'h00);
    write_base(2047, "g");
    write_base(2048, "c");
    query(2047, 13'd4096);
    // Pairs only match when the case agrees.
    write_base(10, "A");
    write_base(11, "t");
    query(10, 12);
    write_base(20, "N");
    write_base(21, "N");
    query(20, 22);
    configure(0, 2);
    query(12'd4095, 13'd4096);
    write_base(30, "G");
    write_base(33, "C");
    query(30, 34);
    configure(4, 0);
    query(1, 4);
  endtask

  initial begin : take_results
    pal_result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.hit        = out_ch.hit;
        got.pal_length = out_ch.pal_length;
        got.start_pos  = out_ch.start_pos;
        got.end_pos    = out_ch.end_pos;
        sb.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL spaced_inverted_repeat_finder");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_WRITE;
    in_ch.index   <= '0;
    in_ch.base    <= '0;
    in_ch.seq_len <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_MIN_LENGTH;
    cfg_ch.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    random_segment(0, 0, 0);
    random_segment(4096, 4095, 0);
    random_segment(6, 1, 1);
    random_segment(3, 2, 1);
    random_segment(8, 0, 2);
    random_segment($urandom_range(12), $urandom_range(6), 2);

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d beats with %0d queries (%0d hits, longest palindrome %0d), %0d reg writes.",
             beats_sent, sb.queries, sb.hits, sb.longest, cfg_writes);
    $display("Spacer ran 0 to 4095 and min_length 0 to 4096 under three idle patterns.");
    if (sb.errors == 0) begin
      $display("PASS spaced_inverted_repeat_finder");
    end else begin
      $display("FAIL spaced_inverted_repeat_finder");
    end
    $finish;
  end

endmodule
